>>> rtl/trpg_pkg.sv
// ----------------------------------------------------------------------------
// trpg_pkg
// Shared types and constants of the tilted ring point generator.
// ----------------------------------------------------------------------------
package trpg_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_POINTS = 64;

  // shared multiplier: signed operands, product truncated to its useful range
  localparam int MUL_IN_W  = 33;
  localparam int MUL_OUT_W = 64;

  // quarter-wave series runs at 30 fractional bits
  localparam logic [30:0] Q30_ONE     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam int          TRIG_SH     = 30 - FRAC_BITS;

  localparam logic [3:0] TIDX_SIN_LAST = 4'd5;
  localparam logic [3:0] TIDX_COS_LAST = 4'd12;

  // configuration register indexes
  localparam logic [2:0] REG_RING_RADIUS   = 3'd0;
  localparam logic [2:0] REG_CENTRE_RADIUS = 3'd1;
  localparam logic [2:0] REG_POINT_COUNT   = 3'd2;
  localparam logic [2:0] REG_DEPTH_ANGLE   = 3'd3;
  localparam logic [2:0] REG_TILT_ANGLE    = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV,
    ST_TG_X,
    ST_TG_SQ,
    ST_TG_SQW,
    ST_TG_M1,
    ST_TG_M2,
    ST_TG_M3,
    ST_TG_M4,
    ST_TG_SM,
    ST_TG_SW,
    ST_TG_FOLD,
    ST_P_X0,
    ST_P_Y0,
    ST_P_Z0,
    ST_P_Z1,
    ST_P_Y1,
    ST_P_X2A,
    ST_P_X2,
    ST_P_Z2A,
    ST_P_Z2,
    ST_P_OUT
  } state_t;

  typedef enum logic [1:0] {
    TD_DEPTH,
    TD_TILT,
    TD_POINT
  } trig_dst_t;

  // series divisors: sine terms first, then cosine terms
  function automatic logic [7:0] series_div(input logic [3:0] idx);
    logic [7:0] d;
    unique case (idx)
      4'd0:    d = 8'd156;
      4'd1:    d = 8'd110;
      4'd2:    d = 8'd72;
      4'd3:    d = 8'd42;
      4'd4:    d = 8'd20;
      4'd5:    d = 8'd6;
      4'd6:    d = 8'd182;
      4'd7:    d = 8'd132;
      4'd8:    d = 8'd90;
      4'd9:    d = 8'd56;
      4'd10:   d = 8'd30;
      4'd11:   d = 8'd12;
      4'd12:   d = 8'd2;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor); the estimate is low by at most one
  function automatic logic [31:0] series_recip(input logic [3:0] idx);
    logic [31:0] m;
    unique case (idx)
      4'd0:    m = 32'd27531841;
      4'd1:    m = 32'd39045157;
      4'd2:    m = 32'd59652323;
      4'd3:    m = 32'd102261126;
      4'd4:    m = 32'd214748364;
      4'd5:    m = 32'd715827882;
      4'd6:    m = 32'd23598721;
      4'd7:    m = 32'd32537631;
      4'd8:    m = 32'd47721858;
      4'd9:    m = 32'd76695844;
      4'd10:   m = 32'd143165576;
      4'd11:   m = 32'd357913941;
      4'd12:   m = 32'd2147483648;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/tilted_ring_point_generator.sv
// ----------------------------------------------------------------------------
// tilted_ring_point_generator
// Emits a tilted ring of points around each centre item.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes one centre (x, y, z, signed
// Q16.16). For it the block emits point_count items (0 counts as 1, capped
// at 64) on the output channel (out_valid / out_stall), point_index 0 first,
// last_point set on the final one. in_stall stays high from acceptance
// until the last point is loaded into the output register, so one centre is
// worked on at a time. All multiplications go through one registered
// multiplier under a sequencer. Per centre: the angle step (bit-serial
// divide), the depth and tilt sine/cosine, then per point its sine/cosine,
// the two rotations and the offset.
// A stalled output holds its item; the next point is computed meanwhile
// and waits in the sequencer until the output register frees up.
// Config port (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready;
// write only while idle. Reset (rst, synchronous) restores register defaults
// and empties the output register.
// ----------------------------------------------------------------------------
module tilted_ring_point_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] centre_x,
  input  logic signed [31:0] centre_y,
  input  logic signed [31:0] centre_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic [5:0]         point_index,
  output logic               last_point,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int F  = trpg_pkg::FRAC_BITS;
  localparam int TS = trpg_pkg::TRIG_SH;

  function automatic logic signed [28:0] rnd_frac(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + (64'sd1 <<< (F - 1));
    s = s >>> F;
    return s[28:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -33'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // configuration
  logic [23:0] ring_radius, centre_radius;
  logic [6:0]  point_count;
  logic [15:0] depth_angle, tilt_angle;

  trpg_pkg::state_t    state, state_next;
  trpg_pkg::trig_dst_t dst;

  // item registers
  logic signed [31:0] cx, cy, cz;
  logic [24:0]        dsum;
  logic [6:0]         n_eff;
  logic [6:0]         div_rem;
  logic [16:0]        div_q;
  logic [4:0]         div_cnt;
  logic [16:0]        ang_q;
  logic [6:0]         ang_r;
  logic [5:0]         k;

  // trig registers
  logic [30:0]        tx;
  logic [31:0]        tx2;
  logic [30:0]        tt;
  logic [31:0]        tv;
  logic [30:0]        tq0;
  logic [3:0]         tidx;
  logic [16:0]        qs;
  logic signed [17:0] sd, cd, sm, cm, st, ct;

  // rotation registers
  logic signed [63:0] acc;
  logic signed [28:0] x0, y0, y1, z1, x2, z2;

  logic signed [trpg_pkg::MUL_IN_W-1:0]  op_a, op_b;
  logic signed [trpg_pkg::MUL_OUT_W-1:0] prod;

  trpg_mul u_mul (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .p   (prod)
  );

  logic in_acc;
  logic emit;
  logic [6:0] n_w;
  logic [15:0] ang;
  logic [7:0] div_rem2;
  logic       div_ge;
  logic [7:0] dcon;
  logic [32:0] corr_rem;
  logic [31:0] corr_q;
  logic [31:0] t_new;
  logic [31:0] qs_sum, qc_sum;
  logic [16:0] qc;
  logic signed [17:0] fs, fc, qs_s, qc_s;
  logic [7:0]  ang_r_sum;
  logic        ang_wrap;
  logic        is_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != trpg_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign emit      = (state == trpg_pkg::ST_P_OUT) && (!out_valid || !out_stall);

  always_comb begin
    if (point_count == 7'd0) begin
      n_w = 7'd1;
    end else if (point_count > 7'(trpg_pkg::MAX_POINTS)) begin
      n_w = 7'(trpg_pkg::MAX_POINTS);
    end else begin
      n_w = point_count;
    end
  end

  always_comb begin
    unique case (dst)
      trpg_pkg::TD_DEPTH: ang = depth_angle;
      trpg_pkg::TD_TILT:  ang = tilt_angle;
      default:            ang = ang_q[15:0];
    endcase
  end

  // 65536 / n, one quotient bit per cycle
  assign div_rem2 = {div_rem, (div_cnt == 5'd16)};
  assign div_ge   = (div_rem2 >= {1'b0, n_eff});

  // quotient estimate correction
  assign dcon     = trpg_pkg::series_div(tidx);
  assign corr_rem = {1'b0, tv} - prod[32:0];
  assign corr_q   = {1'b0, tq0} + {31'd0, (corr_rem >= {25'd0, dcon})};
  assign t_new    = {1'b0, trpg_pkg::Q30_ONE} - corr_q;

  assign qs_sum = {1'b0, prod[60:30]} + (32'd1 << (TS - 1));
  assign qc_sum = {1'b0, tt} + (32'd1 << (TS - 1));
  assign qc     = qc_sum[TS+16:TS];
  assign qs_s   = {1'b0, qs};
  assign qc_s   = {1'b0, qc};

  always_comb begin
    unique case (ang[15:14])
      2'd0: begin fs = qs_s;  fc = qc_s;  end
      2'd1: begin fs = qc_s;  fc = -qs_s; end
      2'd2: begin fs = -qs_s; fc = -qc_s; end
      default: begin fs = -qc_s; fc = qs_s; end
    endcase
  end

  assign ang_r_sum = {1'b0, ang_r} + {1'b0, div_rem};
  assign ang_wrap  = (ang_r_sum >= {1'b0, n_eff});
  assign is_last   = ({1'b0, k} == (n_eff - 7'd1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      trpg_pkg::ST_IDLE:   if (in_acc) state_next = trpg_pkg::ST_DIV;
      trpg_pkg::ST_DIV:    if (div_cnt == 5'd0) state_next = trpg_pkg::ST_TG_X;
      trpg_pkg::ST_TG_X:   state_next = trpg_pkg::ST_TG_SQ;
      trpg_pkg::ST_TG_SQ:  state_next = trpg_pkg::ST_TG_SQW;
      trpg_pkg::ST_TG_SQW: state_next = trpg_pkg::ST_TG_M1;
      trpg_pkg::ST_TG_M1:  state_next = trpg_pkg::ST_TG_M2;
      trpg_pkg::ST_TG_M2:  state_next = trpg_pkg::ST_TG_M3;
      trpg_pkg::ST_TG_M3:  state_next = trpg_pkg::ST_TG_M4;
      trpg_pkg::ST_TG_M4: begin
        priority if (tidx == trpg_pkg::TIDX_SIN_LAST) state_next = trpg_pkg::ST_TG_SM;
        else if (tidx == trpg_pkg::TIDX_COS_LAST) state_next = trpg_pkg::ST_TG_FOLD;
        else state_next = trpg_pkg::ST_TG_M1;
      end
      trpg_pkg::ST_TG_SM:  state_next = trpg_pkg::ST_TG_SW;
      trpg_pkg::ST_TG_SW:  state_next = trpg_pkg::ST_TG_M1;
      trpg_pkg::ST_TG_FOLD: begin
        if (dst == trpg_pkg::TD_POINT) state_next = trpg_pkg::ST_P_X0;
        else state_next = trpg_pkg::ST_TG_X;
      end
      trpg_pkg::ST_P_X0:   state_next = trpg_pkg::ST_P_Y0;
      trpg_pkg::ST_P_Y0:   state_next = trpg_pkg::ST_P_Z0;
      trpg_pkg::ST_P_Z0:   state_next = trpg_pkg::ST_P_Z1;
      trpg_pkg::ST_P_Z1:   state_next = trpg_pkg::ST_P_Y1;
      trpg_pkg::ST_P_Y1:   state_next = trpg_pkg::ST_P_X2A;
      trpg_pkg::ST_P_X2A:  state_next = trpg_pkg::ST_P_X2;
      trpg_pkg::ST_P_X2:   state_next = trpg_pkg::ST_P_Z2A;
      trpg_pkg::ST_P_Z2A:  state_next = trpg_pkg::ST_P_Z2;
      trpg_pkg::ST_P_Z2:   state_next = trpg_pkg::ST_P_OUT;
      trpg_pkg::ST_P_OUT: begin
        if (emit) state_next = is_last ? trpg_pkg::ST_IDLE : trpg_pkg::ST_TG_X;
      end
      default:             state_next = trpg_pkg::ST_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      trpg_pkg::ST_TG_X: begin
        op_a = {19'd0, ang[13:0]};
        op_b = {2'b0, trpg_pkg::HALF_PI_Q30};
      end
      trpg_pkg::ST_TG_SQ: begin
        op_a = {2'b0, prod[44:14]};
        op_b = {2'b0, prod[44:14]};
      end
      trpg_pkg::ST_TG_M1: begin
        op_a = {1'b0, tx2};
        op_b = {2'b0, tt};
      end
      trpg_pkg::ST_TG_M2: begin
        op_a = {1'b0, prod[61:30]};
        op_b = {1'b0, trpg_pkg::series_recip(tidx)};
      end
      trpg_pkg::ST_TG_M3: begin
        op_a = {2'b0, prod[62:32]};
        op_b = {25'd0, dcon};
      end
      trpg_pkg::ST_TG_SM: begin
        op_a = {2'b0, tx};
        op_b = {2'b0, tt};
      end
      trpg_pkg::ST_P_X0: begin
        op_a = {8'd0, dsum};
        op_b = {{15{ct[17]}}, ct};
      end
      trpg_pkg::ST_P_Y0: begin
        op_a = {8'd0, dsum};
        op_b = {{15{st[17]}}, st};
      end
      trpg_pkg::ST_P_Z0: begin
        op_a = {{4{x0[28]}}, x0};
        op_b = {{15{cm[17]}}, cm};
      end
      trpg_pkg::ST_P_Z1: begin
        op_a = {{4{y0[28]}}, y0};
        op_b = {{15{sd[17]}}, sd};
      end
      trpg_pkg::ST_P_Y1: begin
        op_a = {{4{y0[28]}}, y0};
        op_b = {{15{cd[17]}}, cd};
      end
      trpg_pkg::ST_P_X2A: begin
        op_a = {{4{z1[28]}}, z1};
        op_b = {{15{sm[17]}}, sm};
      end
      trpg_pkg::ST_P_X2: begin
        op_a = {{4{x0[28]}}, x0};
        op_b = {{15{sm[17]}}, sm};
      end
      trpg_pkg::ST_P_Z2A: begin
        op_a = {{4{z1[28]}}, z1};
        op_b = {{15{cm[17]}}, cm};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= trpg_pkg::ST_IDLE;
      dst           <= trpg_pkg::TD_DEPTH;
      ring_radius   <= 24'd65536;
      centre_radius <= 24'd65536;
      point_count   <= 7'd8;
      depth_angle   <= 16'd0;
      tilt_angle    <= 16'd0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          trpg_pkg::REG_RING_RADIUS:   ring_radius   <= cfg_data;
          trpg_pkg::REG_CENTRE_RADIUS: centre_radius <= cfg_data;
          trpg_pkg::REG_POINT_COUNT:   point_count   <= cfg_data[6:0];
          trpg_pkg::REG_DEPTH_ANGLE:   depth_angle   <= cfg_data[15:0];
          trpg_pkg::REG_TILT_ANGLE:    tilt_angle    <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        dst <= trpg_pkg::TD_DEPTH;
      end else if (state == trpg_pkg::ST_TG_FOLD) begin
        unique case (dst)
          trpg_pkg::TD_DEPTH: dst <= trpg_pkg::TD_TILT;
          default:            dst <= trpg_pkg::TD_POINT;
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      trpg_pkg::ST_IDLE: begin
        if (in_acc) begin
          cx      <= centre_x;
          cy      <= centre_y;
          cz      <= centre_z;
          dsum    <= {1'b0, ring_radius} + {1'b0, centre_radius};
          n_eff   <= n_w;
          div_rem <= 7'd0;
          div_q   <= 17'd0;
          div_cnt <= 5'd16;
          k       <= 6'd0;
          ang_q   <= 17'd0;
          ang_r   <= 7'd0;
        end
      end
      trpg_pkg::ST_DIV: begin
        div_rem <= div_ge ? 7'(div_rem2 - {1'b0, n_eff}) : div_rem2[6:0];
        div_q   <= {div_q[15:0], div_ge};
        div_cnt <= div_cnt - 5'd1;
      end
      trpg_pkg::ST_TG_SQ:  tx <= prod[44:14];
      trpg_pkg::ST_TG_SQW: begin
        tx2  <= prod[61:30];
        tt   <= trpg_pkg::Q30_ONE;
        tidx <= 4'd0;
      end
      trpg_pkg::ST_TG_M2:  tv  <= prod[61:30];
      trpg_pkg::ST_TG_M3:  tq0 <= prod[62:32];
      trpg_pkg::ST_TG_M4: begin
        tt   <= t_new[30:0];
        tidx <= tidx + 4'd1;
      end
      trpg_pkg::ST_TG_SW: begin
        qs <= qs_sum[TS+16:TS];
        tt <= trpg_pkg::Q30_ONE;
      end
      trpg_pkg::ST_TG_FOLD: begin
        unique case (dst)
          trpg_pkg::TD_DEPTH: begin sd <= fs; cd <= fc; end
          trpg_pkg::TD_TILT:  begin sm <= fs; cm <= fc; end
          default:            begin st <= fs; ct <= fc; end
        endcase
      end
      trpg_pkg::ST_P_Y0:  x0  <= rnd_frac(prod);
      trpg_pkg::ST_P_Z0:  y0  <= rnd_frac(prod);
      trpg_pkg::ST_P_Z1:  acc <= prod;
      trpg_pkg::ST_P_Y1:  z1  <= rnd_frac(prod);
      trpg_pkg::ST_P_X2A: y1  <= rnd_frac(prod);
      trpg_pkg::ST_P_X2:  x2  <= rnd_frac(acc - prod);
      trpg_pkg::ST_P_Z2A: acc <= prod;
      trpg_pkg::ST_P_Z2:  z2  <= rnd_frac(acc + prod);
      trpg_pkg::ST_P_OUT: begin
        if (emit) begin
          k     <= k + 6'd1;
          ang_r <= ang_wrap ? 7'(ang_r_sum - {1'b0, n_eff}) : ang_r_sum[6:0];
          ang_q <= ang_q + div_q + {16'd0, ang_wrap};
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      point_x     <= sat32({cx[31], cx} + {{4{x2[28]}}, x2});
      point_y     <= sat32({cy[31], cy} + {{4{y1[28]}}, y1});
      point_z     <= sat32({cz[31], cz} + {{4{z2[28]}}, z2});
      point_index <= k;
      last_point  <= is_last;
    end
  end

endmodule

>>> rtl/trpg_mul.sv
// ----------------------------------------------------------------------------
// trpg_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module trpg_mul (
  input  logic                                 clk,
  input  logic signed [trpg_pkg::MUL_IN_W-1:0]  a,
  input  logic signed [trpg_pkg::MUL_IN_W-1:0]  b,
  output logic signed [trpg_pkg::MUL_OUT_W-1:0] p
);

  logic signed [2*trpg_pkg::MUL_IN_W-1:0] full;

  assign full = a * b;

  always_ff @(posedge clk) begin
    p <= full[trpg_pkg::MUL_OUT_W-1:0];
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives centres into the tilted ring point generator under random register
// settings, predicts every ring point in fixed point and checks each emitted
// point against the predicted ring, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [5:0]         idx;
    logic               last;
  } ring_point_t;

  class ring_scoreboard;
    ring_point_t pending[$];
    int          errors;
    logic [23:0] ring_r, centre_r;
    logic [6:0]  count;
    logic [15:0] depth, tilt;

    function void set_defaults();
      ring_r = 24'd65536; centre_r = 24'd65536; count = 7'd8; depth = '0; tilt = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        trpg_pkg::REG_RING_RADIUS:   ring_r   = val;
        trpg_pkg::REG_CENTRE_RADIUS: centre_r = val;
        trpg_pkg::REG_POINT_COUNT:   count    = val[6:0];
        trpg_pkg::REG_DEPTH_ANGLE:   depth    = val[15:0];
        trpg_pkg::REG_TILT_ANGLE:    tilt     = val[15:0];
        default: ;
      endcase
    endfunction

    // round to nearest, ties toward +inf
    function longint rnd(longint p);
      longint m;
      if (p >= 0)
        return (p + (64'sd1 <<< (trpg_pkg::FRAC_BITS - 1))) >>> trpg_pkg::FRAC_BITS;
      m = -p + (64'sd1 <<< (trpg_pkg::FRAC_BITS - 1)) - 1;
      return -(m >>> trpg_pkg::FRAC_BITS);
    endfunction

    function void quarter(logic [13:0] r, output longint s, output longint c);
      longint unsigned sdiv[6] = '{156, 110, 72, 42, 20, 6};
      longint unsigned cdiv[7] = '{182, 132, 90, 56, 30, 12, 2};
      longint unsigned x, x2, t, one, half;
      one = 64'd1073741824;
      half = 64'd1 << (trpg_pkg::TRIG_SH - 1);
      x = (64'(r) * 64'd1686629713) >> 14;
      x2 = (x * x) >> 30;
      t = one;
      for (int i = 0; i < 6; i++) t = one - ((x2 * t) >> 30) / sdiv[i];
      t = (x * t) >> 30;
      s = longint'((t + half) >> trpg_pkg::TRIG_SH);
      t = one;
      for (int i = 0; i < 7; i++) t = one - ((x2 * t) >> 30) / cdiv[i];
      c = longint'((t + half) >> trpg_pkg::TRIG_SH);
    endfunction

    function void sincos(logic [15:0] a, output longint s, output longint c);
      longint qs, qc;
      quarter(a[13:0], qs, qc);
      case (a[15:14])
        2'd0: begin s = qs; c = qc; end
        2'd1: begin s = qc; c = -qs; end
        2'd2: begin s = -qs; c = -qc; end
        default: begin s = -qc; c = qs; end
      endcase
    endfunction

    function logic signed [31:0] sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void note_centre(logic signed [31:0] cx, logic signed [31:0] cy,
                              logic signed [31:0] cz);
      longint d, sd, cd, sm, cm, st, ct, x0, y0, y1, z1, x2, z2;
      int n;
      logic [15:0] a;
      ring_point_t p;
      d = longint'(ring_r) + longint'(centre_r);
      n = count;
      if (n == 0) n = 1;
      if (n > trpg_pkg::MAX_POINTS) n = trpg_pkg::MAX_POINTS;
      sincos(depth, sd, cd);
      sincos(tilt, sm, cm);
      for (int k = 0; k < n; k++) begin
        a = 16'((longint'(k) * 65536) / n);
        sincos(a, st, ct);
        x0 = rnd(d * ct);
        y0 = rnd(d * st);
        y1 = rnd(y0 * cd);
        z1 = rnd(y0 * sd);
        x2 = rnd(x0 * cm - z1 * sm);
        z2 = rnd(x0 * sm + z1 * cm);
        p.x = sat(longint'(cx) + x2);
        p.y = sat(longint'(cy) + y1);
        p.z = sat(longint'(cz) + z2);
        p.idx = 6'(k);
        p.last = (k == n - 1);
        pending.push_back(p);
      end
    endfunction

    function void check_point(ring_point_t got);
      ring_point_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected point idx %0d", got.idx);
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.idx !== e.idx ||
          got.last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp (%0d %0d %0d i%0d l%0d) got (%0d %0d %0d i%0d l%0d)",
                   e.x, e.y, e.z, e.idx, e.last, got.x, got.y, got.z, got.idx, got.last);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic signed [31:0] centre_x = 0, centre_y = 0, centre_z = 0;
  logic out_valid, out_stall = 0;
  logic signed [31:0] point_x, point_y, point_z;
  logic [5:0] point_index;
  logic last_point;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [23:0] cfg_data = 0;

  ring_scoreboard sb = new();
  int hold_off = 0;
  bit stall_pattern_on = 0;

  always #10 clk = ~clk;

  tilted_ring_point_generator DUT (.*);

  // receiver: stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (stall_pattern_on) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall <= 1'b0;
    end
    if (!rst && out_valid && !out_stall) begin
      ring_point_t p;
      p.x = point_x; p.y = point_y; p.z = point_z;
      p.idx = point_index; p.last = last_point;
      sb.check_point(p);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_centre(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
    in_valid <= 1'b1; centre_x <= x; centre_y <= y; centre_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_centre(x, y, z);
  endtask

  // sender gap between bursts; valid drops only when a gap follows
  task automatic maybe_gap();
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff - $urandom_range(0, 200000);
      1: return 32'sh80000000 + $urandom_range(0, 200000);
      2: return $urandom_range(0, 400000) - 200000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_config();
    logic [23:0] v;
    v = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 400000));
    write_reg(trpg_pkg::REG_RING_RADIUS, v);
    v = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 400000));
    write_reg(trpg_pkg::REG_CENTRE_RADIUS, v);
    // mostly small rings to keep run time down
    v = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 127))
                                    : 24'($urandom_range(1, 12));
    write_reg(trpg_pkg::REG_POINT_COUNT, v);
    write_reg(trpg_pkg::REG_DEPTH_ANGLE, 24'($urandom));
    write_reg(trpg_pkg::REG_TILT_ANGLE, 24'($urandom));
    if ($urandom_range(0, 3) == 0) write_reg(3'd5 + 3'($urandom_range(0, 2)), 24'($urandom));
  endtask

  initial begin
    sb.set_defaults();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults, then register extremes
    send_centre(0, 0, 0);
    send_centre(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_centre(32'sh80000000, 32'sh80000000, 32'sh80000000);
    drain();
    write_reg(trpg_pkg::REG_RING_RADIUS, 24'hffffff);
    write_reg(trpg_pkg::REG_CENTRE_RADIUS, 24'hffffff);
    write_reg(trpg_pkg::REG_POINT_COUNT, 24'd0);
    write_reg(trpg_pkg::REG_DEPTH_ANGLE, 24'hffff);
    write_reg(trpg_pkg::REG_TILT_ANGLE, 24'hffff);
    send_centre(32'sh7fff0000, 32'sh80010000, 32'sh12345678);
    send_centre(32'sh80000000, 32'sh7fffffff, 32'shedcba987);
    drain();
    write_reg(trpg_pkg::REG_POINT_COUNT, 24'd127);
    write_reg(trpg_pkg::REG_RING_RADIUS, 24'd0);
    write_reg(trpg_pkg::REG_CENTRE_RADIUS, 24'd0);
    write_reg(trpg_pkg::REG_DEPTH_ANGLE, 24'h4000);
    write_reg(trpg_pkg::REG_TILT_ANGLE, 24'h8000);
    send_centre(32'sh00010000, -32'sh00010000, 32'sh55555555);
    drain();
    write_reg(trpg_pkg::REG_POINT_COUNT, 24'd64);
    write_reg(trpg_pkg::REG_RING_RADIUS, 24'h800000);
    write_reg(trpg_pkg::REG_CENTRE_RADIUS, 24'h7fffff);
    write_reg(trpg_pkg::REG_DEPTH_ANGLE, 24'hc000);
    write_reg(trpg_pkg::REG_TILT_ANGLE, 24'h2000);
    write_reg(3'd7, 24'hffffff);
    send_centre(32'shaaaaaaaa, 32'sh55555555, 0);
    drain();
    write_reg(trpg_pkg::REG_POINT_COUNT, 24'd1);
    write_reg(trpg_pkg::REG_RING_RADIUS, 24'd65536);
    write_reg(trpg_pkg::REG_DEPTH_ANGLE, 24'h0001);
    write_reg(trpg_pkg::REG_TILT_ANGLE, 24'h3fff);
    send_centre(-1, 1, 32'sh7fff8000);
    // long output hold-off while the sender keeps offering
    hold_off = 3000;
    send_centre(1, -1, 0);
    send_centre(2, 3, 4);
    send_centre(5, 6, 7);
    drain();

    stall_pattern_on = 1;
    for (int i = 0; i < 400; i++) begin
      if (i % 20 == 0) begin
        drain();
        stall_pattern_on = (i % 40 == 0);
        random_config();
      end
      send_centre(rand_coord(), rand_coord(), rand_coord());
      maybe_gap();
    end
    drain();

    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
